// ===== rtl/gtl_pkg.sv =====
// ----------------------------------------------------------------------------
// gtl_pkg
// Shared constants and types for the glob to LIKE pattern converter.
// ----------------------------------------------------------------------------
`default_nettype none

package gtl_pkg;

    localparam logic [7:0] CH_PERCENT    = 8'h25;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_QUESTION   = 8'h3F;

    // Most result bytes one input byte can release.
    localparam int unsigned MAX_RESULTS = 3;

    // Output queue geometry.
    localparam int unsigned QUEUE_DEPTH = 8;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] like_byte;
        logic       like_end;
    } result_t;

endpackage : gtl_pkg

`default_nettype wire

// ===== rtl/gtl_in_if.sv =====
// ----------------------------------------------------------------------------
// gtl_in_if
// Valid/ready channel that carries glob pattern bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface gtl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pattern_byte;
    logic       pattern_end;

    modport source (output valid, output pattern_byte, output pattern_end, input ready);
    modport sink   (input valid, input pattern_byte, input pattern_end, output ready);
endinterface : gtl_in_if

`default_nettype wire

// ===== rtl/gtl_out_if.sv =====
// ----------------------------------------------------------------------------
// gtl_out_if
// Valid/ready channel that carries LIKE pattern bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface gtl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] like_byte;
    logic       like_end;

    modport source (output valid, output like_byte, output like_end, input ready);
    modport sink   (input valid, input like_byte, input like_end, output ready);
endinterface : gtl_out_if

`default_nettype wire

// ===== rtl/glob_to_like_convert_core.sv =====
// ----------------------------------------------------------------------------
// glob_to_like_convert_core
// Converts a glob pattern byte stream into a SQL LIKE pattern byte stream.
// ----------------------------------------------------------------------------
// One pattern byte is taken per clock cycle while the pattern channel is ready.
// Each transfer is converted in the same cycle and releases zero to three LIKE
// bytes into an eight-entry output queue, which drains one byte per cycle on
// the like channel while the sink is ready. The pattern channel is ready
// whenever the queue has room for three more bytes, so with a like sink that
// is always ready the block sustains one pattern byte per cycle; a stalled
// sink throttles the input through the queue fill level. The final byte of
// each converted pattern carries like_end, and the converter then starts fresh
// for the next pattern.
`default_nettype none

module glob_to_like_convert_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    gtl_in_if.sink      pattern,
    gtl_out_if.source   like
);

    localparam int unsigned AW = gtl_pkg::QUEUE_AW;
    localparam int unsigned CW = gtl_pkg::QUEUE_CW;

    // Conversion state.
    logic [7:0] held_byte_reg, held_byte_next;
    logic       held_valid_reg, held_valid_next;
    logic       star_wait_reg, star_wait_next;
    logic       skip_slash_reg, skip_slash_next;

    // Output queue.
    gtl_pkg::result_t queue_reg [gtl_pkg::QUEUE_DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    gtl_pkg::result_t res [gtl_pkg::MAX_RESULTS];
    logic [1:0]       res_count;

    logic in_xfer;
    logic out_xfer;

    assign pattern.ready = (count_reg <= CW'(gtl_pkg::QUEUE_DEPTH - gtl_pkg::MAX_RESULTS));
    assign in_xfer       = pattern.valid & pattern.ready;

    assign like.valid     = (count_reg != '0);
    assign like.like_byte = queue_reg[rd_ptr_reg].like_byte;
    assign like.like_end  = queue_reg[rd_ptr_reg].like_end;
    assign out_xfer       = like.valid & like.ready;

    // Conversion step. Emitting a byte releases the held byte and holds the new
    // one, so a slash can still be withdrawn by a following double star.
    always_comb
    begin
        logic [7:0] b;
        logic [7:0] hb;
        logic       hv;
        logic       star;
        logic       skip;
        logic       dropped;

        b       = pattern.pattern_byte;
        hb      = held_byte_reg;
        hv      = held_valid_reg;
        star    = star_wait_reg;
        skip    = skip_slash_reg;
        dropped = 1'b0;

        res_count = 2'd0;
        for (int i = 0; i < gtl_pkg::MAX_RESULTS; i++)
        begin
            res[i] = '{like_byte: 8'h00, like_end: 1'b0};
        end

        if (skip)
        begin
            skip = 1'b0;
            dropped = (b == gtl_pkg::CH_SLASH);
        end

        if (!dropped)
        begin
            if (star)
            begin
                star = 1'b0;
                if (b == gtl_pkg::CH_STAR)
                begin
                    // Double star: withdraw a held slash, then emit one percent.
                    if (hv && hb == gtl_pkg::CH_SLASH)
                    begin
                        hv = 1'b0;
                    end
                    if (hv)
                    begin
                        res[res_count] = '{like_byte: hb, like_end: 1'b0};
                        res_count = res_count + 2'd1;
                    end
                    hb   = gtl_pkg::CH_PERCENT;
                    hv   = 1'b1;
                    skip = 1'b1;
                end
                else
                begin
                    if (hv)
                    begin
                        res[res_count] = '{like_byte: hb, like_end: 1'b0};
                        res_count = res_count + 2'd1;
                    end
                    hb = gtl_pkg::CH_PERCENT;
                    hv = 1'b1;
                    if (b == gtl_pkg::CH_STAR)
                    begin
                        star = 1'b1;
                    end
                    else
                    begin
                        res[res_count] = '{like_byte: hb, like_end: 1'b0};
                        res_count = res_count + 2'd1;
                        hb = (b == gtl_pkg::CH_QUESTION) ? gtl_pkg::CH_UNDERSCORE : b;
                    end
                end
            end
            else if (b == gtl_pkg::CH_STAR)
            begin
                star = 1'b1;
            end
            else
            begin
                if (hv)
                begin
                    res[res_count] = '{like_byte: hb, like_end: 1'b0};
                    res_count = res_count + 2'd1;
                end
                hb = (b == gtl_pkg::CH_QUESTION) ? gtl_pkg::CH_UNDERSCORE : b;
                hv = 1'b1;
            end
        end

        if (pattern.pattern_end)
        begin
            if (star)
            begin
                if (hv)
                begin
                    res[res_count] = '{like_byte: hb, like_end: 1'b0};
                    res_count = res_count + 2'd1;
                end
                hb = gtl_pkg::CH_PERCENT;
                hv = 1'b1;
            end
            if (hv)
            begin
                res[res_count] = '{like_byte: hb, like_end: 1'b1};
                res_count = res_count + 2'd1;
            end
            hb   = 8'h00;
            hv   = 1'b0;
            star = 1'b0;
            skip = 1'b0;
        end

        held_byte_next  = hb;
        held_valid_next = hv;
        star_wait_next  = star;
        skip_slash_next = skip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_byte_reg  <= 8'h00;
            held_valid_reg <= 1'b0;
            star_wait_reg  <= 1'b0;
            skip_slash_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            star_wait_reg  <= star_wait_next;
            skip_slash_reg <= skip_slash_next;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(res_count);
            end
            if (out_xfer)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            count_reg <= count_reg + (in_xfer ? CW'(res_count) : CW'(0))
                                   - (out_xfer ? CW'(1) : CW'(0));
        end
    end

    // Queue payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            for (int i = 0; i < gtl_pkg::MAX_RESULTS; i++)
            begin
                if (2'(i) < res_count)
                begin
                    queue_reg[wr_ptr_reg + AW'(i)] <= res[i];
                end
            end
        end
    end

endmodule : glob_to_like_convert_core

`default_nettype wire
